/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the thermal backlight throttle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside of reset.
`define TBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define TBT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define TBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tbt_pkg.sv */
// Types, constants and the level reduction function of the thermal backlight throttle.
`default_nettype none

package tbt_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned TEMP_W  = 18;
  localparam int unsigned REQ_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  typedef enum logic [1:0] {
    STAGE_NORMAL   = 2'd0,
    STAGE_HOT      = 2'd1,
    STAGE_VERY_HOT = 2'd2,
    STAGE_PANIC    = 2'd3
  } stage_t;

  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_SAMPLE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERY_HOT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PANIC_THRESHOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_STEP           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VERY_HOT_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PANIC_STEP         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL          = 3'd6;

  localparam logic signed [TEMP_W-1:0] HOT_THRESHOLD_RST      = 18'sd45000;
  localparam logic signed [TEMP_W-1:0] VERY_HOT_THRESHOLD_RST = 18'sd50000;
  localparam logic signed [TEMP_W-1:0] PANIC_THRESHOLD_RST    = 18'sd55000;
  localparam logic [LEVEL_W-1:0] HOT_STEP_RST      = 8'd3;
  localparam logic [LEVEL_W-1:0] VERY_HOT_STEP_RST = 8'd6;
  localparam logic [LEVEL_W-1:0] PANIC_STEP_RST    = 8'd9;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST     = 8'd30;

  // A level of zero stays zero; otherwise subtract the step and floor at the minimum.
  function automatic logic [LEVEL_W-1:0] reduce_level(input logic [LEVEL_W-1:0] lvl,
                                                      input logic [LEVEL_W-1:0] step,
                                                      input logic [LEVEL_W-1:0] min_lvl);
    logic [LEVEL_W:0] diff;
    logic [LEVEL_W-1:0] res;
    diff = {1'b0, lvl} - {1'b0, step};
    if (lvl == '0) begin
      res = '0;
    end else if (diff[LEVEL_W] || (diff[LEVEL_W-1:0] < min_lvl)) begin
      res = min_lvl;
    end else begin
      res = diff[LEVEL_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/thermal_backlight_throttle.sv */
// Top level of the thermal backlight throttle: input register, decision logic, result register.
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  tdata (low bit up)                          tuser
// s_axis    in         requested_level[15:0], temperature[33:16]   action
// m_axis    out        drive_level[7:0], enable[8], stage[10:9]    level_written
// cfg       in         cfg_data: register value, cfg_index: register number, cfg_wen
//
// Every input transfer gives exactly one result transfer. An item waits in the input register,
// where the decision logic evaluates it against the current state, and then moves into the
// result register; one item per cycle is sustained while m_axis_tready stays high. The state
// registers update when an item moves from the input register into the result register. A
// stalled result register holds the input register, and input ready then follows
// m_axis_tready. Reset is synchronous and empties both registers.

module thermal_backlight_throttle (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // requested_level[15:0], temperature[33:16], zeros
  input  wire logic        s_axis_tuser,   // action
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // drive_level[7:0], enable[8], stage[10:9], zeros
  output logic             m_axis_tuser,   // level_written
  // Configuration write port.
  input  wire logic                           cfg_wen,
  input  wire logic [tbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbt_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic signed [tbt_pkg::TEMP_W-1:0] hot_threshold;
  logic signed [tbt_pkg::TEMP_W-1:0] very_hot_threshold;
  logic signed [tbt_pkg::TEMP_W-1:0] panic_threshold;
  logic [tbt_pkg::LEVEL_W-1:0] hot_step;
  logic [tbt_pkg::LEVEL_W-1:0] very_hot_step;
  logic [tbt_pkg::LEVEL_W-1:0] panic_step;
  logic [tbt_pkg::LEVEL_W-1:0] min_level;

  // Block state.
  logic [tbt_pkg::LEVEL_W-1:0] saved_level;
  tbt_pkg::stage_t             thermal_stage;
  logic                        enable_flag;
  logic [tbt_pkg::LEVEL_W-1:0] saved_level_next;
  tbt_pkg::stage_t             thermal_stage_next;
  logic                        enable_flag_next;

  // Input register.
  logic                              in_valid;
  logic                              in_action;
  logic signed [tbt_pkg::REQ_W-1:0]  in_req;
  logic signed [tbt_pkg::TEMP_W-1:0] in_temp;

  // Result register.
  logic                        out_valid;
  logic                        out_written;
  logic [tbt_pkg::LEVEL_W-1:0] out_drive;
  logic                        out_enable;
  tbt_pkg::stage_t             out_stage;

  // Decision logic.
  logic                        advance;
  logic [tbt_pkg::LEVEL_W-1:0] req_low;
  logic [tbt_pkg::LEVEL_W-1:0] raised;
  logic                        req_take;
  tbt_pkg::stage_t             sample_stage;
  tbt_pkg::stage_t             red_stage;
  logic [tbt_pkg::LEVEL_W-1:0] red_step;
  logic [tbt_pkg::LEVEL_W-1:0] red_in;
  logic [tbt_pkg::LEVEL_W-1:0] red_level;
  logic                        written;
  logic [tbt_pkg::LEVEL_W-1:0] drive;

  // The held item moves on whenever the result register is empty or being drained.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action <= s_axis_tuser;
      in_req    <= s_axis_tdata[15:0];
      in_temp   <= s_axis_tdata[33:16];
    end
  end

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      hot_threshold      <= tbt_pkg::HOT_THRESHOLD_RST;
      very_hot_threshold <= tbt_pkg::VERY_HOT_THRESHOLD_RST;
      panic_threshold    <= tbt_pkg::PANIC_THRESHOLD_RST;
      hot_step           <= tbt_pkg::HOT_STEP_RST;
      very_hot_step      <= tbt_pkg::VERY_HOT_STEP_RST;
      panic_step         <= tbt_pkg::PANIC_STEP_RST;
      min_level          <= tbt_pkg::MIN_LEVEL_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        tbt_pkg::CFG_HOT_THRESHOLD:      hot_threshold      <= cfg_data;
        tbt_pkg::CFG_VERY_HOT_THRESHOLD: very_hot_threshold <= cfg_data;
        tbt_pkg::CFG_PANIC_THRESHOLD:    panic_threshold    <= cfg_data;
        tbt_pkg::CFG_HOT_STEP:           hot_step           <= cfg_data[tbt_pkg::LEVEL_W-1:0];
        tbt_pkg::CFG_VERY_HOT_STEP:      very_hot_step      <= cfg_data[tbt_pkg::LEVEL_W-1:0];
        tbt_pkg::CFG_PANIC_STEP:         panic_step         <= cfg_data[tbt_pkg::LEVEL_W-1:0];
        tbt_pkg::CFG_MIN_LEVEL:          min_level          <= cfg_data[tbt_pkg::LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A request from 1 up to the minimum is raised to it before the other checks. Negative
  // requests and requests above 255 are dropped, and so is a repeat of the saved level.
  assign req_low  = in_req[tbt_pkg::LEVEL_W-1:0];
  assign raised   = ((req_low != '0) && (req_low < min_level)) ? min_level : req_low;
  assign req_take = !in_req[tbt_pkg::REQ_W-1] && (in_req[tbt_pkg::REQ_W-2:tbt_pkg::LEVEL_W] == '0)
                    && (raised != saved_level);

  // Thresholds are tested from the hottest down, so an unordered set still gives one answer.
  always_comb begin
    priority if (in_temp >= panic_threshold) begin
      sample_stage = tbt_pkg::STAGE_PANIC;
    end else if (in_temp >= very_hot_threshold) begin
      sample_stage = tbt_pkg::STAGE_VERY_HOT;
    end else if (in_temp >= hot_threshold) begin
      sample_stage = tbt_pkg::STAGE_HOT;
    end else begin
      sample_stage = tbt_pkg::STAGE_NORMAL;
    end
  end

  // One shared reducer: a request reduces the new level under the current stage, a stage
  // change reduces the saved level under the new stage.
  assign red_stage = (in_action == tbt_pkg::ACT_SAMPLE) ? sample_stage : thermal_stage;
  assign red_in    = (in_action == tbt_pkg::ACT_SAMPLE) ? saved_level : raised;

  always_comb begin
    unique case (red_stage)
      tbt_pkg::STAGE_NORMAL:   red_step = '0;
      tbt_pkg::STAGE_HOT:      red_step = hot_step;
      tbt_pkg::STAGE_VERY_HOT: red_step = very_hot_step;
      tbt_pkg::STAGE_PANIC:    red_step = panic_step;
      default:                 red_step = '0;
    endcase
  end

  assign red_level = tbt_pkg::reduce_level(red_in, red_step, min_level);

  always_comb begin
    saved_level_next   = saved_level;
    thermal_stage_next = thermal_stage;
    enable_flag_next   = enable_flag;
    written            = 1'b0;
    drive              = '0;
    if (in_action == tbt_pkg::ACT_REQUEST) begin
      if (req_take) begin
        if (raised == '0) begin
          // Zero switches the driver off without writing a level.
          enable_flag_next = 1'b0;
          saved_level_next = '0;
        end else begin
          if (saved_level == '0) begin
            enable_flag_next = 1'b1;
          end
          saved_level_next = raised;
          written          = 1'b1;
          drive            = (thermal_stage != tbt_pkg::STAGE_NORMAL) ? red_level : raised;
        end
      end
    end else begin
      // A stage change always rewrites the level, even when that level is zero.
      if (sample_stage != thermal_stage) begin
        thermal_stage_next = sample_stage;
        written            = 1'b1;
        drive              = red_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_level   <= '0;
      thermal_stage <= tbt_pkg::STAGE_NORMAL;
      enable_flag   <= 1'b0;
    end else if (advance) begin
      saved_level   <= saved_level_next;
      thermal_stage <= thermal_stage_next;
      enable_flag   <= enable_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_written <= written;
      out_drive   <= drive;
      out_enable  <= enable_flag_next;
      out_stage   <= thermal_stage_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_written;
  assign m_axis_tdata  = {5'b0, out_stage, out_enable, out_drive};

  // The enable is on exactly when a nonzero level is saved.
  `TBT_ASSERT(a_enable_tracks_level, enable_flag == (saved_level != '0), "enable out of step with saved level")
  // A result without a level write carries a zero drive level.
  `TBT_ASSERT_IMP(a_idle_drive_zero, out_valid && !out_written, out_drive == '0, "drive level set without a write")
  // State only moves when an item leaves the input register.
  `TBT_ASSERT_NEXT(a_state_holds, !advance, $stable(saved_level) && $stable(thermal_stage), "state changed without an item")
  // The stage reported with a result is the stage the block now holds.
  `TBT_ASSERT_NEXT(a_stage_reported, advance, out_stage == thermal_stage, "reported stage differs from held stage")

endmodule

`default_nettype wire

/* test/tb_thermal_backlight_throttle.sv */
// Self-checking testbench for the thermal backlight throttle block.
`timescale 1ns / 100ps

module tb_thermal_backlight_throttle;

  // Index 7 is not decoded by the block; writes to it must have no effect.
  localparam logic [tbt_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
  localparam int TEMP_LO = -40000;
  localparam int TEMP_HI = 125000;

  // One result transfer as the block should present it.
  typedef struct packed {
    logic                        written;
    logic [tbt_pkg::LEVEL_W-1:0] drive;
    logic                        en;
    tbt_pkg::stage_t             stage;
  } backlight_result_t;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [39:0]                    s_axis_tdata;   // requested_level[15:0], temperature[33:16]
  logic                           s_axis_tuser;   // action
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [15:0]                    m_axis_tdata;   // drive_level[7:0], enable[8], stage[10:9]
  logic                           m_axis_tuser;   // level_written
  logic                           cfg_wen;
  logic [tbt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tbt_pkg::CFG_DATA_W-1:0] cfg_data;

  thermal_backlight_throttle dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Our own copy of the configuration registers.
  logic signed [tbt_pkg::TEMP_W-1:0] thr_hot, thr_very_hot, thr_panic;
  logic [tbt_pkg::LEVEL_W-1:0]       step_hot, step_very_hot, step_panic, floor_level;

  // Our own copy of the block state.
  logic [tbt_pkg::LEVEL_W-1:0] saved_lvl;
  tbt_pkg::stage_t             cur_stage;
  logic                        drv_en;

  // Results still owed by the block, oldest first.
  backlight_result_t backlight_due[$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int level_writes = 0;
  int stage_moves  = 0;

  // Idling controls: tx_idle and rx_idle turn random gaps on; rx_hold forces a long
  // stretch of receiver back-pressure, counted down by the receiver process.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit: several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Most gaps are short, a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Level the driver gets from the saved level in the current stage: zero stays zero,
  // otherwise the stage step comes off and the result never drops below the floor.
  function automatic logic [tbt_pkg::LEVEL_W-1:0] throttled_level();
    int lvl;
    if (saved_lvl == '0) return '0;
    lvl = int'(saved_lvl);
    case (cur_stage)
      tbt_pkg::STAGE_HOT:      lvl -= int'(step_hot);
      tbt_pkg::STAGE_VERY_HOT: lvl -= int'(step_very_hot);
      tbt_pkg::STAGE_PANIC:    lvl -= int'(step_panic);
      default:                 ;
    endcase
    if (lvl < int'(floor_level)) lvl = int'(floor_level);
    return lvl[tbt_pkg::LEVEL_W-1:0];
  endfunction

  // Advances our state by one accepted item and queues the result it must produce.
  task automatic predict_backlight(input logic act,
                                   input logic signed [tbt_pkg::REQ_W-1:0] req,
                                   input logic signed [tbt_pkg::TEMP_W-1:0] temp);
    backlight_result_t r;
    int                b;
    int                t;
    tbt_pkg::stage_t   ns;
    r = '0;
    if (act == tbt_pkg::ACT_REQUEST) begin
      b = int'(req);
      // Small nonzero requests are lifted to the floor before anything else.
      if (b > 0 && b < int'(floor_level)) b = int'(floor_level);
      if (b >= 0 && b <= 255 && b[tbt_pkg::LEVEL_W-1:0] != saved_lvl) begin
        if (b == 0) begin
          drv_en    = 1'b0;
          saved_lvl = '0;
        end else begin
          if (saved_lvl == '0) drv_en = 1'b1;
          saved_lvl = b[tbt_pkg::LEVEL_W-1:0];
          r.drive   = (cur_stage != tbt_pkg::STAGE_NORMAL) ? throttled_level()
                                                           : b[tbt_pkg::LEVEL_W-1:0];
          r.written = 1'b1;
        end
      end
    end else begin
      t = int'(temp);
      // Thresholds are tested from the top down, whether or not they are ordered.
      if (t >= int'(thr_panic))         ns = tbt_pkg::STAGE_PANIC;
      else if (t >= int'(thr_very_hot)) ns = tbt_pkg::STAGE_VERY_HOT;
      else if (t >= int'(thr_hot))      ns = tbt_pkg::STAGE_HOT;
      else                              ns = tbt_pkg::STAGE_NORMAL;
      if (ns != cur_stage) begin
        cur_stage = ns;
        r.drive   = throttled_level();
        r.written = 1'b1;
        stage_moves++;
      end
    end
    r.en    = drv_en;
    r.stage = cur_stage;
    backlight_due.push_back(r);
  endtask

  // Offers one item, waits for its transfer, then optionally idles the input.
  task automatic send_item(input logic act, input logic signed [tbt_pkg::REQ_W-1:0] req,
                           input logic signed [tbt_pkg::TEMP_W-1:0] temp);
    int gap;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {6'b0, temp, req};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_backlight(act, req, temp);
    items_sent++;
    if (tx_idle) begin
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Drops the input valid and waits until every owed result has arrived, plus the
  // pipeline depth and some margin, so the block is idle afterwards.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (backlight_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register; only called while the block is idle.
  task automatic write_reg(input logic [tbt_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_data  = val[tbt_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      tbt_pkg::CFG_HOT_THRESHOLD:      thr_hot       = val[tbt_pkg::TEMP_W-1:0];
      tbt_pkg::CFG_VERY_HOT_THRESHOLD: thr_very_hot  = val[tbt_pkg::TEMP_W-1:0];
      tbt_pkg::CFG_PANIC_THRESHOLD:    thr_panic     = val[tbt_pkg::TEMP_W-1:0];
      tbt_pkg::CFG_HOT_STEP:           step_hot      = val[tbt_pkg::LEVEL_W-1:0];
      tbt_pkg::CFG_VERY_HOT_STEP:      step_very_hot = val[tbt_pkg::LEVEL_W-1:0];
      tbt_pkg::CFG_PANIC_STEP:         step_panic    = val[tbt_pkg::LEVEL_W-1:0];
      tbt_pkg::CFG_MIN_LEVEL:          floor_level   = val[tbt_pkg::LEVEL_W-1:0];
      default:                         ;
    endcase
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic write_all(input int hot, input int very_hot, input int panic,
                           input int s_hot, input int s_very_hot, input int s_panic,
                           input int floor_val);
    write_reg(tbt_pkg::CFG_HOT_THRESHOLD, hot);
    write_reg(tbt_pkg::CFG_VERY_HOT_THRESHOLD, very_hot);
    write_reg(tbt_pkg::CFG_PANIC_THRESHOLD, panic);
    write_reg(tbt_pkg::CFG_HOT_STEP, s_hot);
    write_reg(tbt_pkg::CFG_VERY_HOT_STEP, s_very_hot);
    write_reg(tbt_pkg::CFG_PANIC_STEP, s_panic);
    write_reg(tbt_pkg::CFG_MIN_LEVEL, floor_val);
  endtask

  // One random item. Requests lean toward the interesting values (zero, small values
  // below the floor, a repeat of the saved level, out of range); samples lean toward
  // the neighborhood of the current thresholds so that stages change often.
  task automatic random_item();
    int r;
    int v;
    int t;
    int junk;
    junk = int'($urandom());
    r = $urandom_range(0, 99);
    if (r < 45) begin
      r = $urandom_range(0, 99);
      if (r < 8)       v = 0;
      else if (r < 20) v = $urandom_range(1, 40);
      else if (r < 32) v = int'(saved_lvl);
      else if (r < 75) v = $urandom_range(0, 255);
      else if (r < 85) v = $urandom_range(256, 32767);
      else if (r < 92) v = 0 - int'($urandom_range(1, 32768));
      else             v = int'($urandom());
      send_item(tbt_pkg::ACT_REQUEST, v[tbt_pkg::REQ_W-1:0], junk[tbt_pkg::TEMP_W-1:0]);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 20)      t = int'(thr_hot) + int'($urandom_range(0, 6)) - 3;
      else if (r < 40) t = int'(thr_very_hot) + int'($urandom_range(0, 6)) - 3;
      else if (r < 60) t = int'(thr_panic) + int'($urandom_range(0, 6)) - 3;
      else             t = int'($urandom_range(0, TEMP_HI - TEMP_LO)) + TEMP_LO;
      if (t < TEMP_LO) t = TEMP_LO;
      if (t > TEMP_HI) t = TEMP_HI;
      send_item(tbt_pkg::ACT_SAMPLE, junk[tbt_pkg::REQ_W-1:0], t[tbt_pkg::TEMP_W-1:0]);
    end
  endtask

  // Receiver: random stalls when enabled, and a forced long hold when rx_hold is set.
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_axis_tready = 1'b0;
        rx_hold--;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (rx_idle && $urandom_range(0, 99) < 35) stall_left = pick_gap();
      end
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    backlight_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser) level_writes++;
      if (backlight_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = backlight_due.pop_front();
        report_field("level_written", int'(want.written), int'(m_axis_tuser));
        report_field("drive_level", int'(want.drive), int'(m_axis_tdata[7:0]));
        report_field("enable", int'(want.en), int'(m_axis_tdata[8]));
        report_field("stage", int'(want.stage), int'(m_axis_tdata[10:9]));
        report_field("tdata padding", 0, int'(m_axis_tdata[15:11]));
      end
    end
  end

  // Walks the request rules and every stage with the reset thresholds and steps.
  task automatic test_directed();
    send_item(tbt_pkg::ACT_REQUEST, 16'sd0, 18'sd0);       // zero repeats the reset level
    send_item(tbt_pkg::ACT_REQUEST, 16'sd15, 18'sd0);      // lifted to the floor, enable on
    send_item(tbt_pkg::ACT_REQUEST, 16'sd30, 18'sd0);      // repeat after lifting
    send_item(tbt_pkg::ACT_REQUEST, 16'sd255, 18'sd0);     // top of the range
    send_item(tbt_pkg::ACT_REQUEST, 16'sd256, 18'sd0);     // just out of range
    send_item(tbt_pkg::ACT_REQUEST, -16'sd1, 18'sd0);      // negative
    send_item(tbt_pkg::ACT_REQUEST, -16'sd32768, 18'sd0);  // most negative
    send_item(tbt_pkg::ACT_REQUEST, 16'sd32767, 18'sd0);   // most positive
    send_item(tbt_pkg::ACT_SAMPLE, 16'sd0, 18'sd45000);    // hot threshold exactly
    send_item(tbt_pkg::ACT_SAMPLE, 16'sd0, 18'sd49999);    // still hot, nothing written
    send_item(tbt_pkg::ACT_SAMPLE, 16'sd0, 18'sd50000);    // very hot
    send_item(tbt_pkg::ACT_SAMPLE, -16'sd1, 18'sd125000);  // panic at the top temperature
    send_item(tbt_pkg::ACT_REQUEST, 16'sd35, 18'sd0);      // reduction floored at the minimum
    send_item(tbt_pkg::ACT_REQUEST, 16'sd0, 18'sd0);       // enable off
    send_item(tbt_pkg::ACT_SAMPLE, 16'sd0, -18'sd40000);   // back to normal, zero is written
    send_item(tbt_pkg::ACT_REQUEST, 16'sd1, -18'sd1);      // enable on again from zero
    send_item(tbt_pkg::ACT_REQUEST, 16'sd29, 18'sd0);      // lifts to the saved level: repeat
    send_item(tbt_pkg::ACT_SAMPLE, 16'sd0, 18'sd55000);    // panic threshold exactly
    send_item(tbt_pkg::ACT_SAMPLE, 16'sd0, 18'sd54999);    // down one stage
    settle();
  endtask

  // Holds the receiver off for a long stretch while the sender keeps offering
  // back-to-back transfers, so the block fills and stalls its input.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = 80;
    repeat (40) random_item();
    tx_idle = 1'b1;
    settle();
  endtask

  // Extreme register settings, each exercised by a burst of random items.
  task automatic test_config_extremes();
    write_all(TEMP_LO, 0, 60000, 255, 255, 255, 0);        // floor of zero, largest steps
    repeat (90) random_item();
    settle();
    write_all(0, 20000, 40000, 0, 1, 254, 255);            // floor at the top
    repeat (90) random_item();
    settle();
    write_all(TEMP_HI, TEMP_LO, 20000, 7, 50, 100, 1);     // thresholds out of order
    repeat (90) random_item();
    settle();
    write_all(TEMP_LO, TEMP_LO, TEMP_LO, 10, 20, 128, 30); // every sample is panic
    repeat (90) random_item();
    settle();
    write_all(TEMP_HI, TEMP_HI, TEMP_HI, 3, 6, 9, 100);    // only the top is hot
    repeat (90) random_item();
    settle();
    // A write to the undecoded index, then back to the reset values.
    write_reg(CFG_UNUSED_INDEX, int'($urandom_range(0, 262143)));
    write_all(45000, 50000, 55000, 3, 6, 9, 30);
    repeat (90) random_item();
    settle();
  endtask

  // Random settings between segments; every fourth segment runs with no idling.
  task automatic test_random_soak();
    int th [3];
    int tmp;
    int s_hot, s_very_hot, s_panic, floor_val;
    for (int seg = 0; seg < 12; seg++) begin
      for (int k = 0; k < 3; k++) th[k] = int'($urandom_range(0, TEMP_HI - TEMP_LO)) + TEMP_LO;
      if ($urandom_range(0, 3) != 0) begin
        if (th[0] > th[1]) begin tmp = th[0]; th[0] = th[1]; th[1] = tmp; end
        if (th[1] > th[2]) begin tmp = th[1]; th[1] = th[2]; th[2] = tmp; end
        if (th[0] > th[1]) begin tmp = th[0]; th[0] = th[1]; th[1] = tmp; end
      end
      s_hot      = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 255);
      s_very_hot = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 255);
      s_panic    = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 255);
      floor_val  = $urandom_range(0, 3) != 0 ? $urandom_range(0, 60) : $urandom_range(0, 255);
      // Bits above the register width must be dropped by the block.
      s_hot      = s_hot | (int'($urandom_range(0, 1023)) << 8);
      floor_val  = floor_val | (int'($urandom_range(0, 1023)) << 8);
      write_all(th[0], th[1], th[2], s_hot, s_very_hot, s_panic, floor_val);
      tx_idle = (seg % 4 != 0);
      rx_idle = (seg % 4 != 0);
      repeat (100) random_item();
      settle();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_wen       = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    thr_hot       = tbt_pkg::HOT_THRESHOLD_RST;
    thr_very_hot  = tbt_pkg::VERY_HOT_THRESHOLD_RST;
    thr_panic     = tbt_pkg::PANIC_THRESHOLD_RST;
    step_hot      = tbt_pkg::HOT_STEP_RST;
    step_very_hot = tbt_pkg::VERY_HOT_STEP_RST;
    step_panic    = tbt_pkg::PANIC_STEP_RST;
    floor_level   = tbt_pkg::MIN_LEVEL_RST;
    saved_lvl     = '0;
    cur_stage     = tbt_pkg::STAGE_NORMAL;
    drv_en        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_config_extremes();
    test_random_soak();

    settle();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests and samples through directed, stall, register-extreme",
             items_sent);
    $display("and random phases; %0d results, %0d level writes, %0d stage changes.",
             results_seen, level_writes, stage_moves);
    if (errors == 0 && backlight_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
